FILE: hw/rtl/tmn_pkg.sv
// shared types and codes for the token mutex node
package tmn_pkg;

  // input event kinds
  localparam logic [1:0] KIND_WANT  = 2'd0;
  localparam logic [1:0] KIND_REQ   = 2'd1;
  localparam logic [1:0] KIND_TOKEN = 2'd2;
  localparam logic [1:0] KIND_EXIT  = 2'd3;

  // result kinds
  localparam logic [1:0] OUT_GRANT = 2'd0;
  localparam logic [1:0] OUT_BCAST = 2'd1;
  localparam logic [1:0] OUT_TOKEN = 2'd2;

  // configuration register indexes
  localparam logic CFG_NODE_ID     = 1'b0;
  localparam logic CFG_START_TOKEN = 1'b1;

  // a queue slot keeps four bits of the token word
  localparam int QENTRY_BITS = 4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WANT,
    ST_REQ,
    ST_REQ_CHK,
    ST_TOKEN,
    ST_EXIT,
    ST_SCAN,
    ST_POP,
    ST_SEND
  } tmn_state_t;

  typedef enum logic [1:0] {
    PH_RELEASED  = 2'd0,
    PH_REQUESTED = 2'd1,
    PH_GRANTED   = 2'd2
  } tmn_phase_t;

  // queue commands from the sequencer
  typedef struct packed {
    logic append;
    logic pop;
    logic slot_we;
    logic count_we;
  } tmn_qcmd_t;

endpackage

FILE: hw/rtl/tmn_queue.sv
// wait queue of the token: slots, count, membership check and head pop
module tmn_queue import tmn_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmn_qcmd_t                            cmd,
  input  logic [QENTRY_BITS-1:0]               wr_node,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]       wr_slot,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     wr_count,
  input  logic [QENTRY_BITS-1:0]               query,
  input  logic [$clog2(QUEUE_DEPTH)-1:0]       rd_slot,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]     count,
  output logic                                 full,
  output logic                                 found,
  output logic [QENTRY_BITS-1:0]               head,
  output logic [QENTRY_BITS-1:0]               rd_data
);

  localparam int QA = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH+1);

  logic [QENTRY_BITS-1:0] ent_r [QUEUE_DEPTH];
  logic [CW-1:0]          count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.append) begin
      if (!full) count_r <= count_r + CW'(1);
    end else if (cmd.pop) begin
      if (count_r != '0) count_r <= count_r - CW'(1);
    end else if (cmd.count_we) begin
      count_r <= wr_count;
    end
  end

  // only slots below the count move on a pop
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      if (!full) ent_r[count_r[QA-1:0]] <= wr_node;
    end else if (cmd.pop) begin
      for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
        if (CW'(j + 1) < count_r) ent_r[j] <= ent_r[j+1];
      end
    end else if (cmd.slot_we) begin
      ent_r[wr_slot] <= wr_node;
    end
  end

  always_comb begin
    found = 1'b0;
    for (int j = 0; j < QUEUE_DEPTH; j++) begin
      if (CW'(j) < count_r && ent_r[j] == query) found = 1'b1;
    end
  end

  assign count   = count_r;
  assign full    = (count_r == CW'(QUEUE_DEPTH));
  assign head    = ent_r[0];
  assign rd_data = (CW'(rd_slot) < count_r) ? ent_r[rd_slot] : '0;

endmodule

FILE: hw/rtl/token_mutex_node.sv
// one node of token-based broadcast mutual exclusion
// sequence: a request that finds the token free here starts a token run of NODES+QUEUE_DEPTH+1 beats,
//   an exit scans all nodes, then pops the queue head, if any, and sends it the token run
// throughput: one event at a time; a new event is taken only once the sequencer is idle,
//   the node scan walks the number tables one entry per cycle
// reset: synchronous; request and served numbers, queue count and phase clear, no token held
module token_mutex_node import tmn_pkg::*; #(
  parameter int NODES       = 8,
  parameter int QUEUE_DEPTH = 8,
  parameter int SEQ_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [2:0]  in_src_node,
  input  logic [15:0] in_seq_num,
  input  logic [4:0]  in_word_index,
  input  logic [15:0] in_word_value,
  input  logic        in_word_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_dest_node,
  output logic [15:0] out_seq,
  output logic [4:0]  out_index,
  output logic [15:0] out_value,
  output logic        out_last
);

  localparam int NW   = $clog2(NODES);
  localparam int SB   = SEQ_BITS;
  localparam int QA   = $clog2(QUEUE_DEPTH);
  localparam int CW   = $clog2(QUEUE_DEPTH+1);
  localparam int CNTW = $clog2(NODES+QUEUE_DEPTH+1);

  function automatic logic [NW-1:0] node_mod(input logic [2:0] id);
    logic [4:0] v;
    v = {2'b00, id};
    for (int k = 0; k < 8; k++) begin
      if (v >= 5'(NODES)) v = v - 5'(NODES);
    end
    return v[NW-1:0];
  endfunction

  tmn_state_t state_r, state_nxt;
  tmn_phase_t phase_r, phase_nxt;
  logic            holds_r, holds_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [2:0]      dest_r, dest_nxt;
  logic [NW-1:0]   self_r;

  logic [2:0]      src_r;
  logic [SB-1:0]   seq_r;
  logic [4:0]      widx_r;
  logic [15:0]     wval_r;
  logic            wlast_r;

  logic [SB-1:0]   rn_r [NODES];
  logic [SB-1:0]   sn_r [NODES];
  logic [NW-1:0]   rn_addr, sn_addr, rn_wa, sn_wa;
  logic [SB-1:0]   rn_rd, sn_rd, rn_wd, sn_wd;
  logic            rn_we, sn_we;

  tmn_qcmd_t              qcmd;
  logic [QENTRY_BITS-1:0] q_wr_node, q_query, q_head, q_rd;
  logic [QA-1:0]          q_wr_slot, q_rd_slot;
  logic [CW-1:0]          q_wr_count, q_count;
  logic                   q_full, q_found;

  logic        emit, e_last;
  logic [1:0]  e_kind;
  logic [2:0]  e_dest;
  logic [15:0] e_seq, e_value;
  logic [4:0]  e_index;

  logic        out_valid_r, out_last_r;
  logic [1:0]  out_kind_r;
  logic [2:0]  out_dest_r;
  logic [15:0] out_seq_r, out_value_r;
  logic [4:0]  out_index_r;

  logic            accept, slot_free, src_ok, pend;
  logic [NW-1:0]   src_idx, cnt_node;
  logic [SB-1:0]   diff;
  logic [4:0]      tok_off;
  logic [CNTW-1:0] slot_off;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;

  assign src_idx  = NW'(src_r);
  assign src_ok   = ({2'b00, src_r} < 5'(NODES)) && (src_idx != self_r);
  assign cnt_node = cnt_r[NW-1:0];
  assign rn_rd    = rn_r[rn_addr];
  assign sn_rd    = sn_r[sn_addr];
  // shared compare: pending when request is one past served
  assign pend     = (rn_rd == sn_rd + SB'(1));
  assign diff     = seq_r - rn_rd;
  assign tok_off  = widx_r - 5'(NODES);
  assign slot_off = cnt_r - CNTW'(NODES);

  tmn_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (qcmd),
    .wr_node  (q_wr_node),
    .wr_slot  (q_wr_slot),
    .wr_count (q_wr_count),
    .query    (q_query),
    .rd_slot  (q_rd_slot),
    .count    (q_count),
    .full     (q_full),
    .found    (q_found),
    .head     (q_head),
    .rd_data  (q_rd)
  );

  always_comb begin
    state_nxt  = state_r;
    phase_nxt  = phase_r;
    holds_nxt  = holds_r;
    cnt_nxt    = cnt_r;
    dest_nxt   = dest_r;
    rn_addr    = self_r;
    sn_addr    = cnt_node;
    rn_we      = 1'b0;
    rn_wa      = self_r;
    rn_wd      = rn_rd + SB'(1);
    sn_we      = 1'b0;
    sn_wa      = widx_r[NW-1:0];
    sn_wd      = SB'(wval_r);
    qcmd       = '0;
    q_wr_node  = wval_r[QENTRY_BITS-1:0];
    q_wr_slot  = tok_off[QA-1:0];
    q_wr_count = (wval_r > 16'(QUEUE_DEPTH)) ? CW'(QUEUE_DEPTH) : wval_r[CW-1:0];
    q_query    = QENTRY_BITS'(cnt_r);
    q_rd_slot  = slot_off[QA-1:0];
    emit       = 1'b0;
    e_kind     = OUT_GRANT;
    e_dest     = '0;
    e_seq      = '0;
    e_index    = '0;
    e_value    = '0;
    e_last     = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_kind)
            KIND_WANT:  state_nxt = ST_WANT;
            KIND_REQ:   state_nxt = ST_REQ;
            KIND_TOKEN: state_nxt = ST_TOKEN;
            KIND_EXIT:  state_nxt = ST_EXIT;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WANT: begin
        if (phase_r != PH_RELEASED) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          if (holds_r) begin
            phase_nxt = PH_GRANTED;
          end else begin
            rn_we     = 1'b1;
            phase_nxt = PH_REQUESTED;
            e_kind    = OUT_BCAST;
            e_seq     = 16'(rn_wd);
          end
        end
      end
      ST_REQ: begin
        rn_addr = src_idx;
        rn_wa   = src_idx;
        rn_wd   = seq_r;
        if (!src_ok) begin
          state_nxt = ST_IDLE;
        end else begin
          // newer when ahead by less than half the number space
          rn_we     = (diff != '0) && !diff[SB-1];
          state_nxt = ST_REQ_CHK;
        end
      end
      ST_REQ_CHK: begin
        rn_addr = src_idx;
        sn_addr = src_idx;
        cnt_nxt = '0;
        dest_nxt = src_r;
        if (phase_r == PH_RELEASED && holds_r && pend) state_nxt = ST_SEND;
        else state_nxt = ST_IDLE;
      end
      ST_TOKEN: begin
        if (phase_r != PH_REQUESTED || holds_r) begin
          state_nxt = ST_IDLE;
        end else if (!wlast_r || slot_free) begin
          state_nxt = ST_IDLE;
          priority if (widx_r < 5'(NODES)) sn_we = 1'b1;
          else if ({1'b0, widx_r} < 6'(NODES + QUEUE_DEPTH)) qcmd.slot_we = 1'b1;
          else qcmd.count_we = ({1'b0, widx_r} == 6'(NODES + QUEUE_DEPTH));
          if (wlast_r) begin
            holds_nxt = 1'b1;
            phase_nxt = PH_GRANTED;
            emit      = 1'b1;
          end
        end
      end
      ST_EXIT: begin
        if (phase_r != PH_GRANTED) begin
          state_nxt = ST_IDLE;
        end else begin
          phase_nxt = PH_RELEASED;
          sn_we     = 1'b1;
          sn_wa     = self_r;
          sn_wd     = rn_rd;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rn_addr   = cnt_node;
        q_wr_node = QENTRY_BITS'(cnt_r);
        if (cnt_node != self_r && pend && !q_found && !q_full) qcmd.append = 1'b1;
        if (cnt_r == CNTW'(NODES - 1)) state_nxt = ST_POP;
        else cnt_nxt = cnt_r + CNTW'(1);
      end
      ST_POP: begin
        cnt_nxt  = '0;
        dest_nxt = q_head[2:0];
        if (q_count == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          qcmd.pop  = 1'b1;
          state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        e_kind  = OUT_TOKEN;
        e_dest  = dest_r;
        e_index = 5'(cnt_r);
        e_last  = 1'b0;
        priority if (cnt_r < CNTW'(NODES)) e_value = 16'(sn_rd);
        else if (cnt_r < CNTW'(NODES + QUEUE_DEPTH)) e_value = 16'(q_rd);
        else begin
          e_value = 16'(q_count);
          e_last  = 1'b1;
        end
        if (slot_free) begin
          emit    = 1'b1;
          cnt_nxt = cnt_r + CNTW'(1);
          if (e_last) begin
            holds_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we && cfg_index == CFG_START_TOKEN) holds_nxt = cfg_data[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_RELEASED;
      holds_r <= 1'b0;
      cnt_r   <= '0;
      self_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      holds_r <= holds_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we && cfg_index == CFG_NODE_ID) self_r <= node_mod(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    dest_r <= dest_nxt;
    if (accept) begin
      src_r   <= in_src_node;
      seq_r   <= SB'(in_seq_num);
      widx_r  <= in_word_index;
      wval_r  <= in_word_value;
      wlast_r <= in_word_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < NODES; n++) begin
        rn_r[n] <= '0;
        sn_r[n] <= '0;
      end
    end else begin
      if (rn_we) rn_r[rn_wa] <= rn_wd;
      if (sn_we) sn_r[sn_wa] <= sn_wd;
    end
  end

  // output register parts the sequencer from the result channel
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= e_kind;
      out_dest_r  <= e_dest;
      out_seq_r   <= e_seq;
      out_index_r <= e_index;
      out_value_r <= e_value;
      out_last_r  <= e_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_dest_node = out_dest_r;
  assign out_seq       = out_seq_r;
  assign out_index     = out_index_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("sequencer idle right after an input beat");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_kind == OUT_TOKEN && !out_last) |-> state_r == ST_SEND)
    else $error("token run broken before its last beat");

  a_send_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEND |-> holds_r)
    else $error("token sent while not held");

endmodule
